### hw/rtl/assert_macros.svh
// assertion macros for the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property violated");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

### hw/rtl/stci_pkg.sv
// types, constants and codes of the sequence tracker and credit issuer
`default_nettype none

package stci_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int COUNTER_BITS = 48;
    localparam int TIMER_BITS   = 16;

    localparam int STAT_W   = 48;
    localparam int SEQ_W    = 32;
    localparam int LEN_W    = 16;
    localparam int MS_W     = 16;
    localparam int BATCH_W  = 11;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RES  = 4;

    localparam logic [15:0] LINK_MAGIC = 16'hDA01;
    localparam logic [7:0]  TYPE_DATA  = 8'h01;

    localparam logic [15:0]      RST_CREDIT_WINDOW = 16'd2048;
    localparam logic [BATCH_W-1:0] RST_CREDIT_BATCH = 11'd64;
    localparam logic [15:0]      RST_BUSY_REFRESH  = 16'd100;
    localparam logic [15:0]      RST_IDLE_REFRESH  = 16'd10;
    localparam logic [15:0]      RST_IDLE_THRESH   = 16'd500;
    localparam logic [15:0]      RST_NACK_START    = 16'd200;
    localparam logic [15:0]      RST_NACK_STOP     = 16'd5000;
    localparam logic [15:0]      RST_NACK_PERIOD   = 16'd50;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        MSG_STATUS  = 2'd0,
        MSG_CREDIT  = 2'd1,
        MSG_NACK    = 2'd2,
        MSG_DELIVER = 2'd3
    } msg_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CREDIT_WINDOW = 4'd0,
        CFG_CREDIT_BATCH  = 4'd1,
        CFG_BUSY_REFRESH  = 4'd2,
        CFG_IDLE_REFRESH  = 4'd3,
        CFG_IDLE_THRESH   = 4'd4,
        CFG_NACK_START    = 4'd5,
        CFG_NACK_STOP     = 4'd6,
        CFG_NACK_PERIOD   = 4'd7
    } cfg_addr_t;

    typedef struct packed {
        op_t               opcode;
        logic [LEN_W-1:0]  datagram_bytes;
        logic [15:0]       magic_word;
        logic [7:0]        packet_type;
        logic [SEQ_W-1:0]  seq_number;
        logic [LEN_W-1:0]  payload_bytes;
    } item_t;

    typedef struct packed {
        msg_kind_t         msg_kind;
        logic [SEQ_W-1:0]  msg_value;
        logic [LEN_W-1:0]  deliver_bytes;
        logic              last_of_run;
        logic [STAT_W-1:0] rx_packets;
        logic [STAT_W-1:0] processed_packets;
        logic [STAT_W-1:0] out_of_order_packets;
        logic [STAT_W-1:0] gap_total;
        logic [STAT_W-1:0] rx_bytes;
        logic [SEQ_W-1:0]  highest_seen;
        logic [SEQ_W-1:0]  next_expected;
    } result_t;

    typedef struct packed {
        msg_kind_t         kind;
        logic [SEQ_W-1:0]  value;
        logic [LEN_W-1:0]  bytes;
    } slot_t;

endpackage

`default_nettype wire

### hw/rtl/sequence_tracker_credit_issuer_top.sv
// Receive-side sequence tracker and credit issuer of a credit-windowed datagram link.
//
// item channel: item_valid / item_stall carry a datagram header or a one
// millisecond tick (item.opcode). A transfer happens when valid is high and
// stall is low. result channel: result_valid / result_stall, same rule.
// cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. The user must make writes only while the block is idle;
// the block itself does not enforce it. An item lands in an input register,
// is evaluated from there and its one to four results go into a small result
// queue, whose head shows the first result. The queue drains one result per
// cycle while result_stall is low; an item has one or two results for a
// header, one for a plain tick and up to four for a tick with a nack.
// Single-result items stream at one per cycle while results are not stalled.
// The status fields show the state after the whole item; last_of_run marks
// its final result. A stalled result holds; the input register then fills and
// item_stall rises until the queue is down to its last result being taken.
// Reset clears counters and sequence state, sets the granted limit to
// 2048, the nack timer to all ones and the registers to their defaults.
`default_nettype none
`include "assert_macros.svh"

module sequence_tracker_credit_issuer_top #(
    parameter int COUNTER_BITS = stci_pkg::COUNTER_BITS,
    parameter int TIMER_BITS   = stci_pkg::TIMER_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire stci_pkg::item_t                     item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output stci_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [stci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [stci_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SEQ_W   = stci_pkg::SEQ_W;
    localparam int MS_W    = stci_pkg::MS_W;
    localparam int BATCH_W = stci_pkg::BATCH_W;
    localparam int CNT_W   = $clog2(stci_pkg::MAX_RES + 1);
    localparam int SUM_W   = ((COUNTER_BITS > SEQ_W) ? COUNTER_BITS : SEQ_W) + 1;
    localparam int CMP_W   = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    function automatic logic [COUNTER_BITS-1:0] sat_add(
        input logic [COUNTER_BITS-1:0] a,
        input logic [SEQ_W-1:0]        b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return (s > SUM_W'(CNT_MAX)) ? CNT_MAX : s[COUNTER_BITS-1:0];
    endfunction

    function automatic logic [TIMER_BITS-1:0] tmr_inc(input logic [TIMER_BITS-1:0] t);
        return (&t) ? t : t + 1'b1;
    endfunction

    // configuration registers
    logic [15:0]        cfg_window_reg;
    logic [BATCH_W-1:0] cfg_batch_reg;
    logic [15:0]        cfg_busy_reg;
    logic [15:0]        cfg_idle_ref_reg;
    logic [15:0]        cfg_idle_thr_reg;
    logic [15:0]        cfg_nack_start_reg;
    logic [15:0]        cfg_nack_stop_reg;
    logic [15:0]        cfg_nack_period_reg;

    // tracking state
    logic [SEQ_W-1:0]        expected_reg, expected_next;
    logic [SEQ_W-1:0]        highest_reg, highest_next;
    logic [SEQ_W-1:0]        granted_reg, granted_next;
    logic [SEQ_W-1:0]        lcp_reg, lcp_next;
    logic [BATCH_W-1:0]      batch_reg, batch_next;
    logic [TIMER_BITS-1:0]   idle_age_reg, idle_age_next;
    logic [TIMER_BITS-1:0]   credit_age_reg, credit_age_next;
    logic [TIMER_BITS-1:0]   nack_age_reg, nack_age_next;
    logic [COUNTER_BITS-1:0] rx_pkts_reg, rx_pkts_next;
    logic [COUNTER_BITS-1:0] proc_pkts_reg, proc_pkts_next;
    logic [COUNTER_BITS-1:0] ooo_pkts_reg, ooo_pkts_next;
    logic [COUNTER_BITS-1:0] gap_reg, gap_next;
    logic [COUNTER_BITS-1:0] rx_bytes_reg, rx_bytes_next;

    // input register and result queue
    logic              in_full_reg;
    stci_pkg::item_t   in_item_reg;
    stci_pkg::slot_t   slot_reg [stci_pkg::MAX_RES];
    stci_pkg::slot_t   slot_next [stci_pkg::MAX_RES];
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [CNT_W-1:0]  new_cnt;

    logic in_take;
    logic out_take;
    logic proc_go;

    assign cfg_ready    = 1'b1;
    assign result_valid = (res_cnt_reg != '0);
    assign out_take     = result_valid && !result_stall;
    assign proc_go      = in_full_reg &&
                          ((res_cnt_reg == '0) || ((res_cnt_reg == CNT_W'(1)) && out_take));
    assign item_stall   = in_full_reg && !proc_go;
    assign in_take      = item_valid && !item_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_window_reg      <= stci_pkg::RST_CREDIT_WINDOW;
            cfg_batch_reg       <= stci_pkg::RST_CREDIT_BATCH;
            cfg_busy_reg        <= stci_pkg::RST_BUSY_REFRESH;
            cfg_idle_ref_reg    <= stci_pkg::RST_IDLE_REFRESH;
            cfg_idle_thr_reg    <= stci_pkg::RST_IDLE_THRESH;
            cfg_nack_start_reg  <= stci_pkg::RST_NACK_START;
            cfg_nack_stop_reg   <= stci_pkg::RST_NACK_STOP;
            cfg_nack_period_reg <= stci_pkg::RST_NACK_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                stci_pkg::CFG_CREDIT_WINDOW: cfg_window_reg      <= cfg_data;
                stci_pkg::CFG_CREDIT_BATCH:  cfg_batch_reg       <= cfg_data[BATCH_W-1:0];
                stci_pkg::CFG_BUSY_REFRESH:  cfg_busy_reg        <= cfg_data;
                stci_pkg::CFG_IDLE_REFRESH:  cfg_idle_ref_reg    <= cfg_data;
                stci_pkg::CFG_IDLE_THRESH:   cfg_idle_thr_reg    <= cfg_data;
                stci_pkg::CFG_NACK_START:    cfg_nack_start_reg  <= cfg_data;
                stci_pkg::CFG_NACK_STOP:     cfg_nack_stop_reg   <= cfg_data;
                stci_pkg::CFG_NACK_PERIOD:   cfg_nack_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // evaluation of the registered item
    always_comb
    begin
        logic             hdr_ok;
        logic [SEQ_W-1:0] lim;
        logic [SEQ_W-1:0] seq;
        logic [CMP_W-1:0] period;
        logic             any;
        logic [CNT_W-1:0] n;

        expected_next   = expected_reg;
        highest_next    = highest_reg;
        granted_next    = granted_reg;
        lcp_next        = lcp_reg;
        batch_next      = batch_reg;
        idle_age_next   = idle_age_reg;
        credit_age_next = credit_age_reg;
        nack_age_next   = nack_age_reg;
        rx_pkts_next    = rx_pkts_reg;
        proc_pkts_next  = proc_pkts_reg;
        ooo_pkts_next   = ooo_pkts_reg;
        gap_next        = gap_reg;
        rx_bytes_next   = rx_bytes_reg;
        for (int i = 0; i < stci_pkg::MAX_RES; i++)
        begin
            slot_next[i] = '{kind: stci_pkg::MSG_STATUS, value: '0, bytes: '0};
        end
        n      = '0;
        any    = 1'b0;
        lim    = '0;
        period = '0;
        seq    = in_item_reg.seq_number;
        hdr_ok = (in_item_reg.datagram_bytes >= 16'(stci_pkg::HEADER_BYTES)) &&
                 (in_item_reg.magic_word == stci_pkg::LINK_MAGIC) &&
                 (in_item_reg.packet_type == stci_pkg::TYPE_DATA);

        if (in_item_reg.opcode == stci_pkg::OP_HEADER)
        begin
            n = CNT_W'(1);
            if (hdr_ok)
            begin
                rx_pkts_next  = sat_add(rx_pkts_reg, SEQ_W'(1));
                rx_bytes_next = sat_add(rx_bytes_reg, SEQ_W'(in_item_reg.datagram_bytes));
                if (seq > highest_reg)
                begin
                    highest_next = seq;
                end
                idle_age_next = '0;
                if (seq >= expected_reg)
                begin
                    if (seq != expected_reg)
                    begin
                        ooo_pkts_next = sat_add(ooo_pkts_reg, SEQ_W'(1));
                        gap_next      = sat_add(gap_reg, seq - expected_reg);
                    end
                    proc_pkts_next = sat_add(proc_pkts_reg, SEQ_W'(1));
                    expected_next  = seq + 1'b1;
                    slot_next[0]   = '{kind: stci_pkg::MSG_DELIVER, value: seq,
                                       bytes: in_item_reg.payload_bytes};
                end
                batch_next = batch_reg + 1'b1;
                if (batch_next >= cfg_batch_reg)
                begin
                    lim = expected_next + SEQ_W'(cfg_window_reg);
                    if (lim > granted_reg)
                    begin
                        granted_next    = lim;
                        lcp_next        = expected_next;
                        credit_age_next = '0;
                        slot_next[1]    = '{kind: stci_pkg::MSG_CREDIT, value: lim, bytes: '0};
                        n = CNT_W'(2);
                    end
                    batch_next = '0;
                end
            end
        end
        else
        begin
            idle_age_next   = tmr_inc(idle_age_reg);
            credit_age_next = tmr_inc(credit_age_reg);
            nack_age_next   = tmr_inc(nack_age_reg);
            lim = expected_reg + SEQ_W'(cfg_window_reg);

            // credit after the expected sequence moved
            if ((expected_reg != lcp_reg) && (lim > granted_reg))
            begin
                granted_next    = lim;
                lcp_next        = expected_reg;
                credit_age_next = '0;
                slot_next[n[1:0]] = '{kind: stci_pkg::MSG_CREDIT, value: lim, bytes: '0};
                n   = n + 1'b1;
                any = 1'b1;
            end

            // periodic refresh, busy or idle period
            period = (CMP_W'(idle_age_next) > CMP_W'(cfg_idle_thr_reg)) ?
                     CMP_W'(cfg_idle_ref_reg) : CMP_W'(cfg_busy_reg);
            if (CMP_W'(credit_age_next) >= period)
            begin
                granted_next    = lim;
                credit_age_next = '0;
                slot_next[n[1:0]] = '{kind: stci_pkg::MSG_CREDIT, value: lim, bytes: '0};
                n   = n + 1'b1;
                any = 1'b1;
            end

            // nack window while idle
            if ((CMP_W'(idle_age_next) >= CMP_W'(cfg_nack_start_reg)) &&
                (CMP_W'(idle_age_next) <  CMP_W'(cfg_nack_stop_reg)) &&
                (CMP_W'(nack_age_next) >= CMP_W'(cfg_nack_period_reg)))
            begin
                slot_next[n[1:0]] = '{kind: stci_pkg::MSG_NACK, value: expected_reg,
                                      bytes: '0};
                n = n + 1'b1;
                slot_next[n[1:0]] = '{kind: stci_pkg::MSG_CREDIT, value: lim, bytes: '0};
                n = n + 1'b1;
                granted_next  = lim;
                nack_age_next = '0;
                any = 1'b1;
            end

            if (!any)
            begin
                n = CNT_W'(1);
            end
        end
        new_cnt = n;
    end

    always_comb
    begin
        if (proc_go)
        begin
            res_cnt_next = new_cnt;
        end
        else if (out_take)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
        else
        begin
            res_cnt_next = res_cnt_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            res_cnt_reg    <= '0;
            expected_reg   <= '0;
            highest_reg    <= '0;
            granted_reg    <= SEQ_W'(stci_pkg::RST_CREDIT_WINDOW);
            lcp_reg        <= '0;
            batch_reg      <= '0;
            idle_age_reg   <= '0;
            credit_age_reg <= '0;
            nack_age_reg   <= '1;
            rx_pkts_reg    <= '0;
            proc_pkts_reg  <= '0;
            ooo_pkts_reg   <= '0;
            gap_reg        <= '0;
            rx_bytes_reg   <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (in_take)
            begin
                in_full_reg <= 1'b1;
            end
            else if (proc_go)
            begin
                in_full_reg <= 1'b0;
            end
            if (proc_go)
            begin
                expected_reg   <= expected_next;
                highest_reg    <= highest_next;
                granted_reg    <= granted_next;
                lcp_reg        <= lcp_next;
                batch_reg      <= batch_next;
                idle_age_reg   <= idle_age_next;
                credit_age_reg <= credit_age_next;
                nack_age_reg   <= nack_age_next;
                rx_pkts_reg    <= rx_pkts_next;
                proc_pkts_reg  <= proc_pkts_next;
                ooo_pkts_reg   <= ooo_pkts_next;
                gap_reg        <= gap_next;
                rx_bytes_reg   <= rx_bytes_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= item;
        end
        if (proc_go)
        begin
            slot_reg <= slot_next;
        end
        else if (out_take)
        begin
            // queue head moves up by one after each result transfer
            for (int i = 0; i < stci_pkg::MAX_RES - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    // status fields come straight from state, which only moves once the queue drains
    always_comb
    begin
        result.msg_kind             = slot_reg[0].kind;
        result.msg_value            = slot_reg[0].value;
        result.deliver_bytes        = slot_reg[0].bytes;
        result.last_of_run          = (res_cnt_reg == CNT_W'(1));
        result.rx_packets           = stci_pkg::STAT_W'(rx_pkts_reg);
        result.processed_packets    = stci_pkg::STAT_W'(proc_pkts_reg);
        result.out_of_order_packets = stci_pkg::STAT_W'(ooo_pkts_reg);
        result.gap_total            = stci_pkg::STAT_W'(gap_reg);
        result.rx_bytes             = stci_pkg::STAT_W'(rx_bytes_reg);
        result.highest_seen         = highest_reg;
        result.next_expected        = expected_reg;
    end

    `ASSERT_NEVER(a_queue_bound, clk, rst_n, res_cnt_reg > CNT_W'(stci_pkg::MAX_RES))
    `ASSERT_HOLDS(a_item_gives_result, clk, rst_n, proc_go |=> (res_cnt_reg != '0))
    `ASSERT_HOLDS(a_state_held, clk, rst_n,
        !proc_go |=> ($stable(expected_reg) && $stable(granted_reg) && $stable(rx_pkts_reg)))
    `ASSERT_HOLDS(a_processed_le_rx, clk, rst_n,
        (rx_pkts_reg != CNT_MAX) |-> (proc_pkts_reg <= rx_pkts_reg))

endmodule

`default_nettype wire

### dv/sequence_tracker_credit_issuer_top_tb.sv
// self-checking testbench for the sequence tracker and credit issuer top level
module sequence_tracker_credit_issuer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 40;
    localparam int RAND_PHASES = 4;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        bit                      is_cfg;
        logic [3:0]              reg_idx;
        logic [15:0]             reg_val;
        stci_pkg::item_t         it;
        bit                      has_want;
        stci_pkg::slot_t         want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    stci_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    stci_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [stci_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [stci_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // link state tracked alongside the block
    logic [31:0] next_seq, top_seq, granted, credit_point;
    logic [10:0] batch_cnt;
    logic [15:0] idle_ms, credit_ms, nack_ms;
    logic [47:0] rx_cnt, done_cnt, ooo_cnt, gap_cnt, byte_cnt;

    // register copies
    logic [15:0] win, busy_period, idle_period, idle_limit, nack_from, nack_until, nack_gap;
    logic [10:0] batch_len;

    stci_pkg::result_t pending_msgs[$];
    dir_row_t dir_rows[$];

    int fail_count = 0;
    int items_sent = 0;
    int msgs_checked = 0;
    int nacks_seen = 0;
    int credits_seen = 0;
    int cfg_writes = 0;
    int stall_left = 0;
    int calm_left = 0;
    int stall_roll;
    bit calm = 1'b0;

    sequence_tracker_credit_issuer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [15:0] age_up(logic [15:0] t);
        return (t == '1) ? t : t + 16'd1;
    endfunction

    function automatic stci_pkg::slot_t slot(stci_pkg::msg_kind_t k, logic [31:0] v,
                                             logic [15:0] b);
        stci_pkg::slot_t s;
        s.kind = k;
        s.value = v;
        s.bytes = b;
        return s;
    endfunction

    function automatic void link_reset();
        win = stci_pkg::RST_CREDIT_WINDOW;
        batch_len = stci_pkg::RST_CREDIT_BATCH;
        busy_period = stci_pkg::RST_BUSY_REFRESH;
        idle_period = stci_pkg::RST_IDLE_REFRESH;
        idle_limit = stci_pkg::RST_IDLE_THRESH;
        nack_from = stci_pkg::RST_NACK_START;
        nack_until = stci_pkg::RST_NACK_STOP;
        nack_gap = stci_pkg::RST_NACK_PERIOD;
        next_seq = '0;
        top_seq = '0;
        granted = 32'(stci_pkg::RST_CREDIT_WINDOW);
        credit_point = '0;
        batch_cnt = '0;
        idle_ms = '0;
        credit_ms = '0;
        nack_ms = '1;
        rx_cnt = '0;
        done_cnt = '0;
        ooo_cnt = '0;
        gap_cnt = '0;
        byte_cnt = '0;
    endfunction

    function automatic void apply_reg(logic [3:0] idx, logic [15:0] data);
        case (idx)
            stci_pkg::CFG_CREDIT_WINDOW: win = data;
            stci_pkg::CFG_CREDIT_BATCH:  batch_len = data[10:0];
            stci_pkg::CFG_BUSY_REFRESH:  busy_period = data;
            stci_pkg::CFG_IDLE_REFRESH:  idle_period = data;
            stci_pkg::CFG_IDLE_THRESH:   idle_limit = data;
            stci_pkg::CFG_NACK_START:    nack_from = data;
            stci_pkg::CFG_NACK_STOP:     nack_until = data;
            stci_pkg::CFG_NACK_PERIOD:   nack_gap = data;
            default: ;
        endcase
    endfunction

    // work out the messages one accepted item causes and queue them
    function automatic void track_item(stci_pkg::item_t it);
        stci_pkg::slot_t slots[$];
        stci_pkg::result_t r;
        logic [31:0] lim;
        logic [15:0] period;
        if (it.opcode == stci_pkg::OP_HEADER)
        begin
            if (it.datagram_bytes < 16'(stci_pkg::HEADER_BYTES) ||
                it.magic_word != stci_pkg::LINK_MAGIC ||
                it.packet_type != stci_pkg::TYPE_DATA)
            begin
                slots.push_back(slot(stci_pkg::MSG_STATUS, '0, '0));
            end
            else
            begin
                rx_cnt = sat_sum(rx_cnt, 48'd1);
                byte_cnt = sat_sum(byte_cnt, 48'(it.datagram_bytes));
                if (it.seq_number > top_seq)
                    top_seq = it.seq_number;
                idle_ms = '0;
                if (it.seq_number >= next_seq)
                begin
                    if (it.seq_number != next_seq)
                    begin
                        ooo_cnt = sat_sum(ooo_cnt, 48'd1);
                        gap_cnt = sat_sum(gap_cnt, {16'd0, it.seq_number - next_seq});
                    end
                    done_cnt = sat_sum(done_cnt, 48'd1);
                    next_seq = it.seq_number + 32'd1;
                    slots.push_back(slot(stci_pkg::MSG_DELIVER, it.seq_number,
                                         it.payload_bytes));
                end
                else
                begin
                    slots.push_back(slot(stci_pkg::MSG_STATUS, '0, '0));
                end
                batch_cnt = batch_cnt + 11'd1;
                if (batch_cnt >= batch_len)
                begin
                    lim = next_seq + 32'(win);
                    if (lim > granted)
                    begin
                        granted = lim;
                        slots.push_back(slot(stci_pkg::MSG_CREDIT, lim, '0));
                        credit_point = next_seq;
                        credit_ms = '0;
                    end
                    batch_cnt = '0;
                end
            end
        end
        else
        begin
            idle_ms = age_up(idle_ms);
            credit_ms = age_up(credit_ms);
            nack_ms = age_up(nack_ms);
            if (next_seq != credit_point)
            begin
                lim = next_seq + 32'(win);
                if (lim > granted)
                begin
                    granted = lim;
                    slots.push_back(slot(stci_pkg::MSG_CREDIT, lim, '0));
                    credit_point = next_seq;
                    credit_ms = '0;
                end
            end
            period = (idle_ms > idle_limit) ? idle_period : busy_period;
            if (credit_ms >= period)
            begin
                granted = next_seq + 32'(win);
                slots.push_back(slot(stci_pkg::MSG_CREDIT, granted, '0));
                credit_ms = '0;
            end
            if (idle_ms >= nack_from && idle_ms < nack_until && nack_ms >= nack_gap)
            begin
                slots.push_back(slot(stci_pkg::MSG_NACK, next_seq, '0));
                granted = next_seq + 32'(win);
                slots.push_back(slot(stci_pkg::MSG_CREDIT, granted, '0));
                nack_ms = '0;
            end
            if (slots.size() == 0)
                slots.push_back(slot(stci_pkg::MSG_STATUS, '0, '0));
        end
        foreach (slots[k])
        begin
            r.msg_kind = slots[k].kind;
            r.msg_value = slots[k].value;
            r.deliver_bytes = slots[k].bytes;
            r.last_of_run = (k == slots.size() - 1);
            r.rx_packets = rx_cnt;
            r.processed_packets = done_cnt;
            r.out_of_order_packets = ooo_cnt;
            r.gap_total = gap_cnt;
            r.rx_bytes = byte_cnt;
            r.highest_seen = top_seq;
            r.next_expected = next_seq;
            pending_msgs.push_back(r);
        end
    endfunction

    function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_msg(stci_pkg::result_t want, stci_pkg::result_t got);
        cmp_field("msg_kind", 64'(want.msg_kind), 64'(got.msg_kind));
        cmp_field("msg_value", 64'(want.msg_value), 64'(got.msg_value));
        cmp_field("deliver_bytes", 64'(want.deliver_bytes), 64'(got.deliver_bytes));
        cmp_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
        cmp_field("rx_packets", 64'(want.rx_packets), 64'(got.rx_packets));
        cmp_field("processed_packets", 64'(want.processed_packets),
                  64'(got.processed_packets));
        cmp_field("out_of_order_packets", 64'(want.out_of_order_packets),
                  64'(got.out_of_order_packets));
        cmp_field("gap_total", 64'(want.gap_total), 64'(got.gap_total));
        cmp_field("rx_bytes", 64'(want.rx_bytes), 64'(got.rx_bytes));
        cmp_field("highest_seen", 64'(want.highest_seen), 64'(got.highest_seen));
        cmp_field("next_expected", 64'(want.next_expected), 64'(got.next_expected));
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic dir_row_t hdr_row(logic [15:0] len, logic [15:0] magic,
                                         logic [7:0] ptype, logic [31:0] seq,
                                         logic [15:0] pay);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.it.opcode = stci_pkg::OP_HEADER;
        r.it.datagram_bytes = len;
        r.it.magic_word = magic;
        r.it.packet_type = ptype;
        r.it.seq_number = seq;
        r.it.payload_bytes = pay;
        r.has_want = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // tick with every ignored field at all ones
    function automatic dir_row_t tick_row();
        dir_row_t r;
        r = hdr_row('1, '1, '1, '1, '1);
        r.it.opcode = stci_pkg::OP_TICK;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(stci_pkg::cfg_addr_t idx, logic [15:0] val);
        dir_row_t r;
        r = hdr_row('0, '0, '0, '0, '0);
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t want_row(dir_row_t r, stci_pkg::msg_kind_t k,
                                          logic [31:0] v, logic [15:0] b);
        r.has_want = 1'b1;
        r.want = slot(k, v, b);
        return r;
    endfunction

    function automatic stci_pkg::item_t rand_header();
        stci_pkg::item_t it;
        int roll;
        it.opcode = stci_pkg::OP_HEADER;
        it.datagram_bytes = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 15)) :
                                                          16'($urandom_range(16, 65535));
        it.magic_word = ($urandom_range(0, 14) == 0) ? 16'($urandom) : stci_pkg::LINK_MAGIC;
        it.packet_type = ($urandom_range(0, 14) == 0) ? 8'($urandom) : stci_pkg::TYPE_DATA;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            it.seq_number = next_seq;
        else if (roll < 78)
            it.seq_number = next_seq + 32'($urandom_range(1, 6));
        else if (roll < 88)
            it.seq_number = next_seq - 32'($urandom_range(1, 4));
        else if (roll < 94)
            it.seq_number = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        else
            it.seq_number = $urandom;
        it.payload_bytes = 16'($urandom);
        return it;
    endfunction

    function automatic stci_pkg::item_t rand_tick();
        stci_pkg::item_t it;
        it.opcode = stci_pkg::OP_TICK;
        it.datagram_bytes = 16'($urandom);
        it.magic_word = 16'($urandom);
        it.packet_type = 8'($urandom);
        it.seq_number = $urandom;
        it.payload_bytes = 16'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_reg_value(stci_pkg::cfg_addr_t idx, bit extreme);
        bit hi;
        hi = 1'($urandom_range(0, 1));
        case (idx)
            stci_pkg::CFG_CREDIT_WINDOW:
                return extreme ? (hi ? 16'hFFFF : 16'd1) :
                       ($urandom_range(0, 1) ? 16'($urandom_range(1, 16)) :
                                               16'($urandom_range(1, 65535)));
            // upper data bits beyond the 11-bit field are random and must be dropped
            stci_pkg::CFG_CREDIT_BATCH:
                return extreme ? (hi ? 16'd1024 : 16'd1) :
                       {5'($urandom), 11'($urandom_range(1, 6))};
            stci_pkg::CFG_BUSY_REFRESH:
                return extreme ? (hi ? 16'hFFFF : 16'd1) : 16'($urandom_range(1, 40));
            stci_pkg::CFG_IDLE_REFRESH:
                return extreme ? (hi ? 16'hFFFF : 16'd1) : 16'($urandom_range(1, 10));
            stci_pkg::CFG_IDLE_THRESH:
                return extreme ? (hi ? 16'hFFFF : 16'd0) : 16'($urandom_range(0, 15));
            stci_pkg::CFG_NACK_START:
                return extreme ? (hi ? 16'hFFFF : 16'd0) : 16'($urandom_range(0, 10));
            stci_pkg::CFG_NACK_STOP:
                return extreme ? (hi ? 16'hFFFF : 16'd0) : 16'($urandom_range(5, 80));
            stci_pkg::CFG_NACK_PERIOD:
                return extreme ? (hi ? 16'hFFFF : 16'd1) : 16'($urandom_range(1, 8));
            default:
                return '0;
        endcase
    endfunction

    task automatic send_item(stci_pkg::item_t it);
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall !== 1'b0);
        track_item(it);
        items_sent++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = (!calm && $urandom_range(0, 1)) ? gap_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_reg(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_phase(int p);
        wait_idle();
        for (int i = stci_pkg::CFG_CREDIT_WINDOW; i <= stci_pkg::CFG_NACK_PERIOD; i++)
            write_reg(4'(i), pick_reg_value(stci_pkg::cfg_addr_t'(i), p == 1));
        // an index past the register map must leave everything alone
        if (p == RAND_PHASES - 1)
            write_reg({1'b1, 3'($urandom)}, 16'($urandom));
    endtask

    // result side: random stall with calm stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            result_stall <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
            begin
                calm_left = $urandom_range(20, 80);
                result_stall <= 1'b0;
            end
            else if (stall_roll < 30)
            begin
                stall_left = gap_len() - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_msgs.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %0h", $time, result);
                fail_count++;
            end
            else
            begin
                check_msg(pending_msgs.pop_front(), result);
                msgs_checked++;
                if (result.msg_kind == stci_pkg::MSG_NACK)
                    nacks_seen++;
                if (result.msg_kind == stci_pkg::MSG_CREDIT)
                    credits_seen++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("sequence_tracker_credit_issuer_top regression: fail");
        $finish;
    end

    initial
    begin
        int sent;
        int burst;
        bit ticking;
        stci_pkg::result_t last;

        link_reset();

        // defaults after reset: drops, delivery, jump, stale, wrap
        dir_rows.push_back(want_row(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA,
                                            0, 100),
                                    stci_pkg::MSG_DELIVER, 0, 100));
        dir_rows.push_back(want_row(hdr_row(15, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA,
                                            1, 7),
                                    stci_pkg::MSG_STATUS, 0, 0));
        dir_rows.push_back(want_row(hdr_row(16, 16'hDA00, stci_pkg::TYPE_DATA, 1, 7),
                                    stci_pkg::MSG_STATUS, 0, 0));
        dir_rows.push_back(want_row(hdr_row(16, stci_pkg::LINK_MAGIC, 8'h00, 1, 7),
                                    stci_pkg::MSG_STATUS, 0, 0));
        dir_rows.push_back(want_row(hdr_row(16, stci_pkg::LINK_MAGIC, 8'hFF, 1, 7),
                                    stci_pkg::MSG_STATUS, 0, 0));
        dir_rows.push_back(want_row(hdr_row(16'hFFFF, stci_pkg::LINK_MAGIC,
                                            stci_pkg::TYPE_DATA, 1, 16'hFFFF),
                                    stci_pkg::MSG_DELIVER, 1, 16'hFFFF));
        dir_rows.push_back(want_row(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA,
                                            5, 0),
                                    stci_pkg::MSG_DELIVER, 5, 0));
        dir_rows.push_back(want_row(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA,
                                            3, 9),
                                    stci_pkg::MSG_STATUS, 0, 0));
        dir_rows.push_back(tick_row());
        dir_rows.push_back(want_row(hdr_row(16'(stci_pkg::HEADER_BYTES), stci_pkg::LINK_MAGIC,
                                            stci_pkg::TYPE_DATA, 32'hFFFF_FFFF, 16'h1234),
                                    stci_pkg::MSG_DELIVER, 32'hFFFF_FFFF, 16'h1234));
        dir_rows.push_back(want_row(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA,
                                            0, 1),
                                    stci_pkg::MSG_DELIVER, 0, 1));
        dir_rows.push_back(want_row(hdr_row(0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF),
                                    stci_pkg::MSG_STATUS, 0, 0));
        dir_rows.push_back(tick_row());
        // busiest corner, batch of zero checks on every header
        dir_rows.push_back(cfg_row(stci_pkg::CFG_CREDIT_WINDOW, 16'hFFFF));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_CREDIT_BATCH, 16'd0));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_BUSY_REFRESH, 16'd1));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_IDLE_REFRESH, 16'd1));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_IDLE_THRESH, 16'd0));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_NACK_START, 16'd0));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_NACK_STOP, 16'hFFFF));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_NACK_PERIOD, 16'd1));
        dir_rows.push_back(tick_row());
        dir_rows.push_back(tick_row());
        dir_rows.push_back(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA, 1, 16'h0042));
        dir_rows.push_back(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA, 2, 16'h0043));
        dir_rows.push_back(tick_row());
        // quietest corner
        dir_rows.push_back(cfg_row(stci_pkg::CFG_CREDIT_WINDOW, 16'd1));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_CREDIT_BATCH, 16'd1024));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_BUSY_REFRESH, 16'hFFFF));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_IDLE_REFRESH, 16'hFFFF));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_IDLE_THRESH, 16'hFFFF));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_NACK_START, 16'hFFFF));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_NACK_STOP, 16'd0));
        dir_rows.push_back(cfg_row(stci_pkg::CFG_NACK_PERIOD, 16'hFFFF));
        dir_rows.push_back(hdr_row(16, stci_pkg::LINK_MAGIC, stci_pkg::TYPE_DATA, 3, 16'h0044));
        dir_rows.push_back(tick_row());
        dir_rows.push_back(tick_row());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[n])
        begin
            if (dir_rows[n].is_cfg)
            begin
                wait_idle();
                write_reg(dir_rows[n].reg_idx, dir_rows[n].reg_val);
            end
            else
            begin
                send_item(dir_rows[n].it);
                if (dir_rows[n].has_want)
                begin
                    last = pending_msgs[$];
                    if (last.msg_kind != dir_rows[n].want.kind ||
                        last.msg_value != dir_rows[n].want.value ||
                        last.deliver_bytes != dir_rows[n].want.bytes)
                    begin
                        $display("%0t: directed row %0d predicted %0h, row says %0h",
                                 $time, n, {last.msg_kind, last.msg_value, last.deliver_bytes},
                                 dir_rows[n].want);
                        fail_count++;
                    end
                end
                idle_gap();
            end
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_phase(p);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 16);
                ticking = ($urandom_range(0, 2) == 0);
                calm = ($urandom_range(0, 4) == 0);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    send_item(ticking ? rand_tick() : rand_header());
                    sent++;
                    idle_gap();
                end
                // let the result side run dry now and then
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        $display("covered %0d items, %0d results checked, %0d register writes",
                 items_sent, msgs_checked, cfg_writes);
        $display("credit grants seen %0d, nacks seen %0d, mismatches %0d",
                 credits_seen, nacks_seen, fail_count);
        if (fail_count == 0)
            $display("sequence_tracker_credit_issuer_top regression: pass");
        else
            $display("sequence_tracker_credit_issuer_top regression: fail");
        $finish;
    end

endmodule
